>>> rtl/adc_seq_pkg.sv
// Shared types, codes and constants for the ADC scan sequencer.
// Channel tables, opcode and update codes, window sizes and divider constants.
// No dependencies.
`default_nettype none

package adc_seq_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int CHAN_W       = 5;
  localparam int TIMER_W      = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;

  localparam int LONG_WINDOW  = 10;
  localparam int SHORT_WINDOW = 3;
  localparam int WIN_MAX      = (LONG_WINDOW > SHORT_WINDOW) ? LONG_WINDOW : SHORT_WINDOW;

  // position in a window, window size / fill count, window sum
  localparam int POS_W        = $clog2(WIN_MAX);
  localparam int CNT_W        = $clog2(WIN_MAX + 2);
  localparam int SUM_W        = SAMPLE_W + $clog2(WIN_MAX);
  localparam int NUM_SLOTS    = 3;
  localparam int SLOT_W       = 2;
  localparam int MEM_DEPTH    = (1 << SLOT_W) << POS_W;

  // floor(2^SUM_W / size); one correction step fixes the estimate
  localparam logic [SUM_W-1:0] LONG_RECIP  = SUM_W'((1 << SUM_W) / LONG_WINDOW);
  localparam logic [SUM_W-1:0] SHORT_RECIP = SUM_W'((1 << SUM_W) / SHORT_WINDOW);
  localparam logic [CNT_W-1:0] LONG_SIZE   = CNT_W'(LONG_WINDOW);
  localparam logic [CNT_W-1:0] SHORT_SIZE  = CNT_W'(SHORT_WINDOW);

  localparam logic [SLOT_W-1:0] SLOT_VIN  = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_BAT8 = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_BAT9 = 2'd2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_SCAN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPK_TEST  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIC_TEST  = 2'd3;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd500;

  // first converter channels
  localparam logic [CHAN_W-1:0] FCH_TEMP   = 5'd2;
  localparam logic [CHAN_W-1:0] FCH_BAT8   = 5'd8;
  localparam logic [CHAN_W-1:0] FCH_BAT9   = 5'd9;
  localparam logic [CHAN_W-1:0] FCH_GPS_LO = 5'd12;
  localparam logic [CHAN_W-1:0] FCH_GPS_HI = 5'd13;
  // second converter channels
  localparam logic [CHAN_W-1:0] SCH_VIN    = 5'd2;
  localparam logic [CHAN_W-1:0] SCH_VMIC   = 5'd7;
  localparam logic [CHAN_W-1:0] SCH_MIC_P  = 5'd8;
  localparam logic [CHAN_W-1:0] SCH_CALL   = 5'd3;
  localparam logic [CHAN_W-1:0] SCH_SPK_P  = 5'd4;
  localparam logic [CHAN_W-1:0] SCH_SPK_N  = 5'd15;
  localparam logic [CHAN_W-1:0] CH_NONE    = 5'd31;

  localparam logic [2:0] FIRST_LAST_STEP  = 3'd4;
  localparam logic [2:0] SECOND_LAST_STEP = 3'd5;
  localparam logic [2:0] SPK_STEP         = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK           = 3'd0,
    OP_FIRST_DONE     = 3'd1,
    OP_SECOND_DONE    = 3'd2,
    OP_BEGIN          = 3'd3,
    OP_RESTART_SECOND = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    UPD_NONE   = 4'd0,
    UPD_TEMP   = 4'd1,
    UPD_BAT8   = 4'd2,
    UPD_BAT9   = 4'd3,
    UPD_GPS_LO = 4'd4,
    UPD_GPS_HI = 4'd5,
    UPD_VIN    = 4'd6,
    UPD_VMIC   = 4'd7,
    UPD_MIC_P  = 4'd8,
    UPD_CALL   = 4'd9,
    UPD_SPK_P  = 4'd10,
    UPD_SPK_N  = 4'd11
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_MUL,
    ST_FIX,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                start_first;
    logic [CHAN_W-1:0]   first_channel;
    logic                start_second;
    logic [CHAN_W-1:0]   second_channel;
    upd_t                update_code;
    logic [SAMPLE_W-1:0] update_value;
    logic                speaker_path_on;
  } res_t;

  function automatic logic [CHAN_W-1:0] first_seq(input logic [2:0] step);
    logic [CHAN_W-1:0] ch;
    unique case (step)
      3'd0:    ch = FCH_TEMP;
      3'd1:    ch = FCH_BAT8;
      3'd2:    ch = FCH_BAT9;
      3'd3:    ch = FCH_GPS_LO;
      default: ch = FCH_GPS_HI;
    endcase
    return ch;
  endfunction

  function automatic logic [CHAN_W-1:0] second_seq(input logic [2:0] step);
    logic [CHAN_W-1:0] ch;
    unique case (step)
      3'd0:    ch = SCH_VIN;
      3'd1:    ch = SCH_VMIC;
      3'd2:    ch = SCH_MIC_P;
      3'd3:    ch = SCH_CALL;
      3'd4:    ch = SCH_SPK_P;
      default: ch = SCH_SPK_N;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> rtl/adc_scan_sequencer_with_averaging_core.sv
// A plain transaction is captured in the result register at acceptance and moves to the
// output register when the output is not stalled; a windowed mean passes SUM, DRAIN, MUL
// and FIX first. No new transaction is taken until the result is in the output register;
// while summing, the window memory's single read port gives one entry per cycle.
// Reset (rst, synchronous, active high): control state and configuration return to
// defaults at once; window memory is not cleared (every entry is written before use).
//
// ADC scan sequencer top level. Depends on adc_seq_pkg.
`default_nettype none

module adc_scan_sequencer_with_averaging_core
  import adc_seq_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  // input transactions
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [2:0]            opcode,
  input  wire  [SAMPLE_W-1:0]   sample,
  // result transactions
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  start_first,
  output logic [CHAN_W-1:0]     first_channel,
  output logic                  start_second,
  output logic [CHAN_W-1:0]     second_channel,
  output logic [3:0]            update_code,
  output logic [SAMPLE_W-1:0]   update_value,
  output logic                  speaker_path_on,
  // configuration writes
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_W-1:0]      cfg_data
);

  // ---------------------------------------------------------------- config
  logic [TIMER_W-1:0] timeout_ticks;
  logic               extended_scan;
  logic               speaker_test;
  logic               mic_test;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      extended_scan <= 1'b1;
      speaker_test  <= 1'b0;
      mic_test      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:  timeout_ticks <= cfg_data;
        REG_EXT_SCAN: extended_scan <= cfg_data[0];
        REG_SPK_TEST: speaker_test  <= cfg_data[0];
        REG_MIC_TEST: mic_test      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- sequencer state
  logic                running, running_next;
  logic [2:0]          first_step, first_step_next;
  logic [2:0]          second_step, second_step_next;
  logic [CHAN_W-1:0]   first_current_channel, first_current_channel_next;
  logic [CHAN_W-1:0]   second_current_channel, second_current_channel_next;
  logic [TIMER_W-1:0]  idle_count, idle_count_next;
  logic [POS_W-1:0]    window_positions [0:NUM_SLOTS-1];
  logic [CNT_W-1:0]    window_fills     [0:NUM_SLOTS-1];

  state_t              state, state_next;
  res_t                res;       // result being built
  res_t                out_res;   // output register

  // window memory: three windows, one row of 2^POS_W entries each
  logic [SAMPLE_W-1:0] win_mem [0:MEM_DEPTH-1];
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_vld;
  logic [SLOT_W-1:0]   cur_slot;
  logic [CNT_W-1:0]    cur_size;
  logic [POS_W-1:0]    cnt;
  logic [SUM_W-1:0]    acc;
  logic [2*SUM_W-1:0]  prod;

  // handshake strobes
  logic accept;
  logic load_out;
  logic rd_en;

  // ------------------------------------------------------ next-channel logic
  // first converter: steps past the list wrap to the head
  logic [2:0]        fs_st, fs_step;
  logic [CHAN_W-1:0] fs_chan;
  always_comb begin
    fs_st   = (first_step <= FIRST_LAST_STEP) ? first_step : 3'd0;
    fs_chan = first_seq(fs_st);
    fs_step = (fs_st == FIRST_LAST_STEP) ? 3'd0 : fs_st + 3'd1;
  end

  function automatic logic ss_out_of_list(input logic [2:0] st, input logic ext);
    return (st > SECOND_LAST_STEP) || (!ext && (st != 3'd1));
  endfunction

  // second converter: two-channel scan alternates 0/1, six-channel wraps at 5
  logic [2:0]        ss_st, ss_step;
  logic [CHAN_W-1:0] ss_chan;
  logic              ss_spk;
  always_comb begin
    if (ss_out_of_list(second_step, extended_scan)) begin
      ss_st = 3'd0;
    end else begin
      ss_st = second_step;
    end
    ss_chan = second_seq(ss_st);
    if (!extended_scan) begin
      ss_step = (ss_st == 3'd0) ? 3'd1 : 3'd0;
    end else begin
      ss_step = (ss_st == SECOND_LAST_STEP) ? 3'd0 : ss_st + 3'd1;
    end
    ss_spk = (ss_st == SPK_STEP) && speaker_test;
  end

  // saturating idle timer increment
  logic [TIMER_W-1:0] idle_inc;
  assign idle_inc = (idle_count != '1) ? idle_count + TIMER_W'(1) : idle_count;

  // ---------------------------------------------------------- opcode decode
  logic                start_f, start_s, spk_on;
  upd_t                code;
  logic [SAMPLE_W-1:0] value;
  logic                push;
  logic [SLOT_W-1:0]   push_slot;

  always_comb begin
    running_next                = running;
    first_step_next             = first_step;
    second_step_next            = second_step;
    first_current_channel_next  = first_current_channel;
    second_current_channel_next = second_current_channel;
    idle_count_next             = idle_count;
    start_f   = 1'b0;
    start_s   = 1'b0;
    spk_on    = 1'b0;
    code      = UPD_NONE;
    value     = '0;
    push      = 1'b0;
    push_slot = SLOT_VIN;

    unique case (opcode)
      OP_BEGIN: begin
        running_next                = 1'b1;
        start_f                     = 1'b1;
        first_step_next             = fs_step;
        first_current_channel_next  = fs_chan;
        start_s                     = 1'b1;
        second_step_next            = ss_step;
        second_current_channel_next = ss_chan;
        spk_on                      = ss_spk;
        idle_count_next             = '0;
      end
      OP_RESTART_SECOND: begin
        second_step_next = 3'd0;
      end
      OP_TICK: begin
        if (running) begin
          idle_count_next = idle_inc;
          if (idle_inc > timeout_ticks) begin
            start_f                    = 1'b1;
            first_step_next            = fs_step;
            first_current_channel_next = fs_chan;
            idle_count_next            = '0;
          end
        end
      end
      OP_FIRST_DONE: begin
        if (running) begin
          value = sample;
          unique case (first_current_channel)
            FCH_TEMP:   code = UPD_TEMP;
            FCH_BAT8: begin
              code      = UPD_BAT8;
              push      = 1'b1;
              push_slot = SLOT_BAT8;
            end
            FCH_BAT9: begin
              code      = UPD_BAT9;
              push      = 1'b1;
              push_slot = SLOT_BAT9;
            end
            FCH_GPS_LO: code = UPD_GPS_LO;
            FCH_GPS_HI: code = UPD_GPS_HI;
            default:    code = UPD_NONE;
          endcase
          start_f                    = 1'b1;
          first_step_next            = fs_step;
          first_current_channel_next = fs_chan;
          idle_count_next            = '0;
        end
      end
      OP_SECOND_DONE: begin
        if (running) begin
          value = sample;
          unique case (second_current_channel)
            SCH_VIN: begin
              code      = UPD_VIN;
              push      = 1'b1;
              push_slot = SLOT_VIN;
            end
            SCH_VMIC:  code = UPD_VMIC;
            SCH_MIC_P: code = mic_test ? UPD_MIC_P : UPD_NONE;
            SCH_CALL:  code = UPD_CALL;
            SCH_SPK_P: code = speaker_test ? UPD_SPK_P : UPD_NONE;
            SCH_SPK_N: code = speaker_test ? UPD_SPK_N : UPD_NONE;
            default:   code = UPD_NONE;
          endcase
          start_s                     = 1'b1;
          second_step_next            = ss_step;
          second_current_channel_next = ss_chan;
          spk_on                      = ss_spk;
          idle_count_next             = '0;
        end
      end
      default: ;
    endcase

    if (code == UPD_NONE) begin
      value = '0;
    end
  end

  // ------------------------------------------------------- window bookkeeping
  logic [CNT_W-1:0] push_size;
  logic [POS_W-1:0] pos_cur, pos_w, pos_next;
  logic [CNT_W-1:0] fill_cur;
  logic             need_mean;

  always_comb begin
    push_size = (push_slot == SLOT_VIN) ? SHORT_SIZE : LONG_SIZE;
    pos_cur   = window_positions[push_slot];
    fill_cur  = window_fills[push_slot];
    pos_w     = (CNT_W'(pos_cur) >= push_size) ? '0 : pos_cur;
    pos_next  = (CNT_W'(pos_w) == push_size - CNT_W'(1)) ? '0 : pos_w + POS_W'(1);
    // window full once the count passes the size; then the mean is reported
    need_mean = fill_cur > push_size;
  end

  // ---------------------------------------------------------- divide by size
  logic [SUM_W-1:0] cur_recip;
  logic [SUM_W-1:0] q_est, q_times, rem, q_fix;

  always_comb begin
    cur_recip = (cur_slot == SLOT_VIN) ? SHORT_RECIP : LONG_RECIP;
    q_est     = prod[2*SUM_W-1:SUM_W];
    q_times   = q_est * SUM_W'(cur_size);
    rem       = acc - q_times;
    q_fix     = (rem >= SUM_W'(cur_size)) ? q_est + SUM_W'(1) : q_est;
  end

  // ------------------------------------------------------------- FSM: next
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (push && need_mean) ? ST_SUM : ST_EMIT;
        end
      end
      ST_SUM: begin
        if (CNT_W'(cnt) == cur_size - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_MUL;
      ST_MUL:   state_next = ST_FIX;
      ST_FIX:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------- FSM: outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    accept   = in_valid && (state == ST_IDLE);
    load_out = (state == ST_EMIT) && (!out_valid || !out_stall);
    rd_en    = (state == ST_SUM);
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= ST_IDLE;
      running                <= 1'b0;
      first_step             <= 3'd0;
      second_step            <= 3'd0;
      first_current_channel  <= CH_NONE;
      second_current_channel <= CH_NONE;
      idle_count             <= '0;
      out_valid              <= 1'b0;
      rd_vld                 <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        window_positions[i] <= '0;
        window_fills[i]     <= '0;
      end
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (accept) begin
        running                <= running_next;
        first_step             <= first_step_next;
        second_step            <= second_step_next;
        first_current_channel  <= first_current_channel_next;
        second_current_channel <= second_current_channel_next;
        idle_count             <= idle_count_next;
        if (push) begin
          window_positions[push_slot] <= pos_next;
          if (!need_mean) begin
            window_fills[push_slot] <= fill_cur + CNT_W'(1);
          end
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      res.start_first     <= start_f;
      res.first_channel   <= first_current_channel_next;
      res.start_second    <= start_s;
      res.second_channel  <= second_current_channel_next;
      res.update_code     <= code;
      res.update_value    <= value;
      res.speaker_path_on <= spk_on;
      cur_slot            <= push_slot;
      cur_size            <= push_size;
      cnt                 <= '0;
      acc                 <= '0;
    end else begin
      if (rd_en) begin
        cnt <= cnt + POS_W'(1);
      end
      if (rd_vld) begin
        acc <= acc + SUM_W'(rd_data);
      end
    end
    if (state == ST_MUL) begin
      prod <= (2*SUM_W)'(acc) * (2*SUM_W)'(cur_recip);
    end
    if (state == ST_FIX) begin
      res.update_value <= q_fix[SAMPLE_W-1:0];
    end
    if (load_out) begin
      out_res <= res;
    end
  end

  // window memory: write at acceptance, read one entry a cycle while summing
  always_ff @(posedge clk) begin
    if (accept && push) begin
      win_mem[{push_slot, pos_w}] <= sample;
    end
    if (rd_en) begin
      rd_data <= win_mem[{cur_slot, cnt}];
    end
  end

  assign start_first     = out_res.start_first;
  assign first_channel   = out_res.first_channel;
  assign start_second    = out_res.start_second;
  assign second_channel  = out_res.second_channel;
  assign update_code     = out_res.update_code;
  assign update_value    = out_res.update_value;
  assign speaker_path_on = out_res.speaker_path_on;

  // ------------------------------------------------------------ assertions
  // every accepted transaction leaves a result pending
  a_accept_pending: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted transaction left no pending result");

  // reciprocal estimate is off by at most one
  a_div_one_fix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |-> (rem < (SUM_W'(cur_size) + SUM_W'(cur_size))))
    else $error("quotient estimate needs more than one correction");

  // a mean of 12-bit samples stays in range
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |-> (q_fix <= SUM_W'(SAMPLE_MAX)))
    else $error("window mean out of sample range");

  // after a load the result is presented and input opens again
  a_load_then_idle: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && !in_stall))
    else $error("output load did not return to idle");

endmodule

`default_nettype wire

>>> dv/adc_scan_sequencer_with_averaging_core_tb.sv
// Testbench for adc_scan_sequencer_with_averaging_core: random and directed scan traffic.
// It predicts every result in a scoreboard class and checks each one in order.
// Depends on adc_seq_pkg and the core RTL only.
`timescale 1ns / 1ps

module adc_scan_sequencer_with_averaging_core_tb;
  import adc_seq_pkg::*;

  // Opcodes above the last defined one are accepted and ignored by the core.
  localparam int FIRST_UNUSED_OP = 5;
  localparam int LAST_OP         = 7;
  // Printing stops after this many mismatch lines; counting goes on.
  localparam int MAX_PRINTED     = 200;
  // Settle time at the end, scaled from LONG_WINDOW.
  localparam int SETTLE_CYCLES   = 2 * (LONG_WINDOW + 5);

  // Scoreboard: its own copy of the sequencer state and configuration, plus the
  // queue of results that accepted transactions are due to produce.
  class scan_scoreboard;
    logic [TIMER_W-1:0]  timeout_ticks;
    bit                  ext_scan;
    bit                  spk_test;
    bit                  mic_test;
    bit                  running;
    int unsigned         first_pos;
    int unsigned         second_pos;
    logic [CHAN_W-1:0]   first_chan;
    logic [CHAN_W-1:0]   second_chan;
    logic [TIMER_W-1:0]  idle_ticks;
    logic [SAMPLE_W-1:0] win_mem[NUM_SLOTS][WIN_MAX];
    int unsigned         win_pos[NUM_SLOTS];
    int unsigned         win_fill[NUM_SLOTS];
    logic [CHAN_W-1:0]   first_order[5];
    logic [CHAN_W-1:0]   second_order[6];
    res_t                expected_q[$];
    int unsigned         errors;
    int unsigned         results_seen;

    function new();
      first_order  = '{FCH_TEMP, FCH_BAT8, FCH_BAT9, FCH_GPS_LO, FCH_GPS_HI};
      second_order = '{SCH_VIN, SCH_VMIC, SCH_MIC_P, SCH_CALL, SCH_SPK_P, SCH_SPK_N};
      timeout_ticks = TIMEOUT_RESET;
      ext_scan      = 1'b1;
      spk_test      = 1'b0;
      mic_test      = 1'b1;
      running       = 1'b0;
      first_pos     = 0;
      second_pos    = 0;
      first_chan    = CH_NONE;
      second_chan   = CH_NONE;
      idle_ticks    = '0;
      foreach (win_pos[i]) begin
        win_pos[i]  = 0;
        win_fill[i] = 0;
      end
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_TIMEOUT:  timeout_ticks = data[TIMER_W-1:0];
        REG_EXT_SCAN: ext_scan      = data[0];
        REG_SPK_TEST: spk_test      = data[0];
        REG_MIC_TEST: mic_test      = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Sliding mean: raw sample until the fill count passes the size, then sum / size.
    function logic [SAMPLE_W-1:0] push_window(int slot, logic [SAMPLE_W-1:0] smp);
      int unsigned size;
      int unsigned pos;
      int unsigned total;
      size = (slot == SLOT_VIN) ? SHORT_WINDOW : LONG_WINDOW;
      pos  = win_pos[slot];
      if (pos >= size) pos = 0;
      win_mem[slot][pos] = smp;
      win_pos[slot] = (pos + 1) % size;
      if (win_fill[slot] > size) begin
        total = 0;
        for (int i = 0; i < size; i++) total += win_mem[slot][i];
        return SAMPLE_W'(total / size);
      end
      win_fill[slot]++;
      return smp;
    endfunction

    function void step_first(inout res_t r);
      int unsigned st;
      st = (first_pos < $size(first_order)) ? first_pos : 0;
      first_chan = first_order[st];
      first_pos  = (st + 1) % $size(first_order);
      r.start_first = 1'b1;
    endfunction

    // Narrow scan alternates steps 0 and 1; anything else falls back to step 0.
    function void step_second(inout res_t r);
      int unsigned st;
      st = second_pos;
      if (st >= $size(second_order) || (!ext_scan && st != 1)) st = 0;
      second_chan = second_order[st];
      if (ext_scan) second_pos = (st + 1) % $size(second_order);
      else          second_pos = (st == 0) ? 1 : 0;
      if (st == SPK_STEP && spk_test) r.speaker_path_on = 1'b1;
      r.start_second = 1'b1;
    endfunction

    function void note_input(logic [2:0] op, logic [SAMPLE_W-1:0] smp);
      res_t r;
      r = '0;
      if (op == OP_BEGIN) begin
        running = 1'b1;
        step_first(r);
        step_second(r);
        idle_ticks = '0;
      end else if (op == OP_RESTART_SECOND) begin
        second_pos = 0;
      end else if (running && op == OP_TICK) begin
        if (idle_ticks != '1) idle_ticks++;
        if (idle_ticks > timeout_ticks) begin
          step_first(r);
          idle_ticks = '0;
        end
      end else if (running && op == OP_FIRST_DONE) begin
        case (first_chan)
          FCH_TEMP:   begin r.update_code = UPD_TEMP;   r.update_value = smp; end
          FCH_BAT8:   begin
            r.update_code  = UPD_BAT8;
            r.update_value = push_window(SLOT_BAT8, smp);
          end
          FCH_BAT9:   begin
            r.update_code  = UPD_BAT9;
            r.update_value = push_window(SLOT_BAT9, smp);
          end
          FCH_GPS_LO: begin r.update_code = UPD_GPS_LO; r.update_value = smp; end
          FCH_GPS_HI: begin r.update_code = UPD_GPS_HI; r.update_value = smp; end
          default: ;
        endcase
        step_first(r);
        idle_ticks = '0;
      end else if (running && op == OP_SECOND_DONE) begin
        case (second_chan)
          SCH_VIN:   begin
            r.update_code  = UPD_VIN;
            r.update_value = push_window(SLOT_VIN, smp);
          end
          SCH_VMIC:  begin r.update_code = UPD_VMIC; r.update_value = smp; end
          SCH_MIC_P: if (mic_test) begin r.update_code = UPD_MIC_P; r.update_value = smp; end
          SCH_CALL:  begin r.update_code = UPD_CALL; r.update_value = smp; end
          SCH_SPK_P: if (spk_test) begin r.update_code = UPD_SPK_P; r.update_value = smp; end
          SCH_SPK_N: if (spk_test) begin r.update_code = UPD_SPK_N; r.update_value = smp; end
          default: ;
        endcase
        step_second(r);
        idle_ticks = '0;
      end
      r.first_channel  = first_chan;
      r.second_channel = second_chan;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task cmp_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                  results_seen, name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        return;
      end
      want = expected_q.pop_front();
      cmp_field("start_first",     got.start_first,     want.start_first);
      cmp_field("first_channel",   got.first_channel,   want.first_channel);
      cmp_field("start_second",    got.start_second,    want.start_second);
      cmp_field("second_channel",  got.second_channel,  want.second_channel);
      cmp_field("update_code",     got.update_code,     want.update_code);
      cmp_field("update_value",    got.update_value,    want.update_value);
      cmp_field("speaker_path_on", got.speaker_path_on, want.speaker_path_on);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           opcode = '0;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 start_first;
  logic [CHAN_W-1:0]    first_channel;
  logic                 start_second;
  logic [CHAN_W-1:0]    second_channel;
  logic [3:0]           update_code;
  logic [SAMPLE_W-1:0]  update_value;
  logic                 speaker_path_on;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  scan_scoreboard sb;
  res_t           seen_result;
  // Idle percentages per phase, and a long receiver hold-off request in cycles.
  int             gap_pct = 0;
  int             stall_pct = 0;
  int             hold_req = 0;

  adc_scan_sequencer_with_averaging_core u_top (
    .clk, .rst,
    .in_valid, .in_stall, .opcode, .sample,
    .out_valid, .out_stall,
    .start_first, .first_channel, .start_second, .second_channel,
    .update_code, .update_value, .speaker_path_on,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver side. A hold-off request keeps stall high for that many cycles,
  // counted here, while the sender keeps offering transactions.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor: values sampled at the edge are the ones the core saw.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen_result.start_first     = start_first;
      seen_result.first_channel   = first_channel;
      seen_result.start_second    = start_second;
      seen_result.second_channel  = second_channel;
      seen_result.update_code     = upd_t'(update_code);
      seen_result.update_value    = update_value;
      seen_result.speaker_path_on = speaker_path_on;
      sb.check_result(seen_result);
    end
  end

  // Offer one transaction, with random idle cycles ahead of it. Valid stays high
  // afterwards so back-to-back transactions need no extra edge.
  task automatic send_item(input logic [2:0] op, input logic [SAMPLE_W-1:0] smp);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    sample   <= smp;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(op, smp);
  endtask

  // Drop valid and wait until every predicted result has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // One-bit registers get random upper bits; only bit 0 should matter.
  function automatic logic [CFG_W-1:0] flag_word(bit b);
    return (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'(b);
  endfunction

  // Writes all four registers, one per edge; only called while the core is idle.
  task automatic write_config(input logic [TIMER_W-1:0] tmo, input bit ext, input bit spk,
                              input bit mic);
    logic [CFG_W-1:0] vals[4];
    vals[REG_TIMEOUT]  = tmo;
    vals[REG_EXT_SCAN] = flag_word(ext);
    vals[REG_SPK_TEST] = flag_word(spk);
    vals[REG_MIC_TEST] = flag_word(mic);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Samples lean on the extremes so window sums hit their top end.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return SAMPLE_MAX;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Mostly completions on both converters, some ticks, rare begins and restarts,
  // a little noise on the unused opcodes.
  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 34) return OP_FIRST_DONE;
    if (r < 68) return OP_SECOND_DONE;
    if (r < 84) return OP_TICK;
    if (r < 90) return OP_BEGIN;
    if (r < 96) return OP_RESTART_SECOND;
    return 3'($urandom_range(FIRST_UNUSED_OP, LAST_OP));
  endfunction

  // Ticks come in bursts so small timeouts actually expire.
  task automatic random_items(input int n);
    int         sent;
    int         burst;
    logic [2:0] op;
    sent = 0;
    while (sent < n) begin
      op    = pick_op();
      burst = (op == OP_TICK) ? $urandom_range(1, 8) : 1;
      repeat (burst) send_item(op, pick_sample());
      if (op < FIRST_UNUSED_OP) sent += burst;
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset configuration, no idling.
    // Before the first begin everything but restart is ignored.
    send_item(OP_TICK, SAMPLE_MAX);
    send_item(OP_FIRST_DONE, SAMPLE_MAX);
    send_item(OP_SECOND_DONE, '0);
    send_item(3'(FIRST_UNUSED_OP), 12'hA5A);
    send_item(OP_RESTART_SECOND, 12'h5A5);
    send_item(OP_BEGIN, '0);
    // One full first-converter lap: temp, both battery windows, gps low and high.
    send_item(OP_FIRST_DONE, '0);
    repeat (4) send_item(OP_FIRST_DONE, SAMPLE_MAX);
    // Full extended second lap; speaker captures disabled by default.
    repeat (6) send_item(OP_SECOND_DONE, pick_sample());
    send_item(OP_TICK, '0);
    send_item(OP_BEGIN, SAMPLE_MAX);              // begin while already running
    send_item(OP_SECOND_DONE, SAMPLE_MAX);
    send_item(OP_RESTART_SECOND, '0);             // restart mid-sequence
    send_item(OP_SECOND_DONE, 12'h555);
    send_item(3'(LAST_OP), SAMPLE_MAX);
    send_item(OP_FIRST_DONE, 12'hAAA);
    drain();

    // Timeout 0: every tick restarts; narrow scan, speaker on, mic off.
    write_config('0, 1'b0, 1'b1, 1'b0);
    random_items(150);
    drain();

    // Timeout never expires; sender idles.
    gap_pct = 47;
    write_config('1, 1'b1, 1'b1, 1'b1);
    random_items(150);
    drain();

    // Short timeout; receiver stalls.
    gap_pct   = 0;
    stall_pct = 47;
    write_config(TIMER_W'(5), 1'b1, 1'b0, 1'b0);
    random_items(150);
    drain();

    // Both sides idle a little; long receiver hold-off in the middle fills the core.
    gap_pct   = 11;
    stall_pct = 11;
    write_config(TIMER_W'(3), 1'b0, 1'b0, 1'b1);
    random_items(60);
    hold_req = 80;
    random_items(90);
    drain();

    // Mixed idling on both sides with everything enabled.
    gap_pct   = 25;
    stall_pct = 25;
    write_config(TIMER_W'(100), 1'b1, 1'b1, 1'b1);
    random_items(200);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
